// File: sv/pfwt_pkg.sv
// Shared types and constants for the point fusion block.
// Used by every module of the block and by its checker.
package pfwt_pkg;

	localparam int RUN_DEPTH  = 16;
	localparam int ID_BITS    = 20;
	localparam int COORD_BITS = 32;
	localparam int TOL_BITS   = 31;
	localparam int GROUP_BITS = 20;

	typedef struct packed {
		logic                          start_of_set;
		logic signed [COORD_BITS-1:0] bucket_code;
		logic signed [COORD_BITS-1:0] coord_x;
		logic signed [COORD_BITS-1:0] coord_y;
		logic signed [COORD_BITS-1:0] coord_z;
	} pfwt_in_t;

	typedef struct packed {
		logic                  fused;
		logic [GROUP_BITS-1:0] group_id;
		logic                  run_overflow;
	} pfwt_out_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} pfwt_point_t;

endpackage

// File: sv/pfwt_cell.sv
// One cell of the run row: holds one stored point and its group id.
// Depends on pfwt_pkg for the point type.
module pfwt_cell #(
	parameter int IdBits = pfwt_pkg::ID_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift_en,
	input  logic                          probe_en,
	input  pfwt_pkg::pfwt_point_t         probe,
	input  logic [pfwt_pkg::TOL_BITS-1:0] tol,
	input  pfwt_pkg::pfwt_point_t         prev_point,
	input  logic [IdBits-1:0]             prev_id,
	output pfwt_pkg::pfwt_point_t         point,
	output logic [IdBits-1:0]             id,
	output logic                          hit
);

	pfwt_pkg::pfwt_point_t point_q;
	logic [IdBits-1:0]     id_q;
	logic                  hit_q;
	logic                  near_x, near_y, near_z;

	// |a - b| < t  <=>  a - b - t < 0  and  a - b + t > 0
	function automatic logic near(
		input logic [pfwt_pkg::COORD_BITS-1:0] a,
		input logic [pfwt_pkg::COORD_BITS-1:0] b,
		input logic [pfwt_pkg::TOL_BITS-1:0]   t
	);
		logic [pfwt_pkg::COORD_BITS+1:0] a_ext, b_ext, t_ext, lo, hi;
		a_ext = {{2{a[pfwt_pkg::COORD_BITS-1]}}, a};
		b_ext = {{2{b[pfwt_pkg::COORD_BITS-1]}}, b};
		t_ext = {3'b000, t};
		lo    = a_ext - b_ext - t_ext;
		hi    = a_ext - b_ext + t_ext;
		return lo[pfwt_pkg::COORD_BITS+1] && !hi[pfwt_pkg::COORD_BITS+1] && (hi != '0);
	endfunction

	assign near_x = near(probe.x, point_q.x, tol);
	assign near_y = near(probe.y, point_q.y, tol);
	assign near_z = near(probe.z, point_q.z, tol);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			point_q <= prev_point;
			id_q    <= prev_id;
		end
		if (probe_en) begin
			hit_q <= near_x && near_y && near_z;
		end
	end

	assign point = point_q;
	assign id    = id_q;
	assign hit   = hit_q;

	// arst_n kept on the port so the row wires all cells alike; payload needs no reset
	logic unused_rst;
	assign unused_rst = arst_n;

endmodule

// File: sv/pfwt_row.sv
// Shifting row of cells holding the newest points of the current run,
// plus the newest-first selection of the first matching cell.
// Depends on pfwt_pkg and pfwt_cell.
module pfwt_row #(
	parameter int Depth  = pfwt_pkg::RUN_DEPTH,
	parameter int IdBits = pfwt_pkg::ID_BITS,
	localparam int AvailW = $clog2(Depth + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift_en,
	input  logic                          probe_en,
	input  pfwt_pkg::pfwt_point_t         probe,
	input  logic [pfwt_pkg::TOL_BITS-1:0] tol,
	input  pfwt_pkg::pfwt_point_t         new_point,
	input  logic [IdBits-1:0]             new_id,
	input  logic [AvailW-1:0]             avail,
	output logic                          match,
	output logic [IdBits-1:0]             match_id
);

	pfwt_pkg::pfwt_point_t pts [Depth];
	logic [IdBits-1:0]     ids [Depth];
	logic [Depth-1:0]      hits;
	logic [Depth-1:0]      live_hits;

	for (genvar g = 0; g < Depth; g++) begin : g_cell
		pfwt_pkg::pfwt_point_t prev_point;
		logic [IdBits-1:0]     prev_id;

		if (g == 0) begin : g_head
			assign prev_point = new_point;
			assign prev_id    = new_id;
		end else begin : g_link
			assign prev_point = pts[g-1];
			assign prev_id    = ids[g-1];
		end

		pfwt_cell #(.IdBits(IdBits)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (shift_en),
			.probe_en  (probe_en),
			.probe     (probe),
			.tol       (tol),
			.prev_point(prev_point),
			.prev_id   (prev_id),
			.point     (pts[g]),
			.id        (ids[g]),
			.hit       (hits[g])
		);

		// ignore cells beyond the filled part of the run
		assign live_hits[g] = hits[g] && (AvailW'(g) < avail);
	end

	// newest cell wins: scan oldest to newest, last hit kept
	always_comb begin
		match    = 1'b0;
		match_id = '0;
		for (int i = Depth - 1; i >= 0; i--) begin
			if (live_hits[i]) begin
				match    = 1'b1;
				match_id = ids[i];
			end
		end
	end

endmodule

// File: sv/point_fuse_within_tolerance.sv
// Top level of the tolerance point fusion block.
// Depends on pfwt_pkg and pfwt_row.
//
// Points arrive sorted by bucket code and leave with a group id; a point
// that lies strictly within the tolerance on every axis of a stored point of
// the same run takes that point's id and is flagged fused. A compare stage
// checks the point against all stored points of the cell row at once; a
// pick stage then takes the newest match, advances the id counter, shifts
// the point into the row and loads the output register, stalling while it
// still holds a result not yet taken. The next point may be accepted as
// the pick stage advances. The user must write the tolerance register
// only while no point is in flight; the block itself does not enforce it.
module point_fuse_within_tolerance #(
	parameter int RunDepth = pfwt_pkg::RUN_DEPTH,
	parameter int IdBits   = pfwt_pkg::ID_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  pfwt_pkg::pfwt_in_t            in_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output pfwt_pkg::pfwt_out_t           out_word,
	input  logic                          cfg_we,
	input  logic [pfwt_pkg::TOL_BITS-1:0] cfg_wdata
);

	localparam int LenW   = $clog2(RunDepth + 2);
	localparam int AvailW = $clog2(RunDepth + 1);

	logic [pfwt_pkg::TOL_BITS-1:0] tol_q;
	logic [LenW-1:0]               run_len_q;
	logic [pfwt_pkg::COORD_BITS-1:0] run_code_q;
	logic [IdBits-1:0]             next_id_q;

	logic                  v_s1, v_s2;
	pfwt_pkg::pfwt_in_t    word_s1;
	pfwt_pkg::pfwt_point_t point_s2;
	logic [pfwt_pkg::COORD_BITS-1:0] code_s2;
	logic [LenW-1:0]       len_s2;
	logic [IdBits-1:0]     next_s2;

	logic                  out_valid_q;
	pfwt_pkg::pfwt_out_t   out_word_q;

	logic                  accept, s2_adv;
	pfwt_pkg::pfwt_point_t probe_s1;
	logic [LenW-1:0]       eff_len;
	logic [IdBits-1:0]     eff_next;
	logic                  overflow_s2;
	logic [AvailW-1:0]     avail_s2;
	logic                  match;
	logic [IdBits-1:0]     match_id, id_s2;
	logic [pfwt_pkg::GROUP_BITS-1:0] group_s2;

	assign s2_adv   = v_s2 && (!out_valid_q || !out_stall);
	assign in_stall = v_s1 || (v_s2 && !s2_adv);
	assign accept   = in_valid && !in_stall;

	assign probe_s1 = '{x: word_s1.coord_x, y: word_s1.coord_y, z: word_s1.coord_z};

	// a new set or a code change empties the run
	always_comb begin
		if (word_s1.start_of_set) begin
			eff_len = '0;
		end else if (run_len_q != '0 && word_s1.bucket_code != run_code_q) begin
			eff_len = '0;
		end else begin
			eff_len = run_len_q;
		end
		eff_next = word_s1.start_of_set ? '0 : next_id_q;
	end

	assign overflow_s2 = len_s2 > LenW'(RunDepth);
	assign avail_s2    = overflow_s2 ? AvailW'(RunDepth) : len_s2[AvailW-1:0];
	assign id_s2       = match ? match_id : next_s2;

	if (IdBits >= pfwt_pkg::GROUP_BITS) begin : g_group_trunc
		assign group_s2 = id_s2[pfwt_pkg::GROUP_BITS-1:0];
	end else begin : g_group_ext
		assign group_s2 = {{(pfwt_pkg::GROUP_BITS - IdBits){1'b0}}, id_s2};
	end

	pfwt_row #(.Depth(RunDepth), .IdBits(IdBits)) u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (s2_adv),
		.probe_en (v_s1),
		.probe    (probe_s1),
		.tol      (tol_q),
		.new_point(point_s2),
		.new_id   (id_s2),
		.avail    (avail_s2),
		.match    (match),
		.match_id (match_id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= '0;
			run_len_q   <= '0;
			run_code_q  <= '0;
			next_id_q   <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			v_s1 <= accept;
			v_s2 <= v_s1 || (v_s2 && !s2_adv);
			if (s2_adv) begin
				out_valid_q <= 1'b1;
				run_code_q  <= code_s2;
				if (len_s2 <= LenW'(RunDepth)) begin
					run_len_q <= len_s2 + LenW'(1);
				end else begin
					run_len_q <= len_s2;
				end
				// advance the id only for a distinct point, saturate at all ones
				if (!match && next_s2 != '1) begin
					next_id_q <= next_s2 + IdBits'(1);
				end else begin
					next_id_q <= next_s2;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_word;
		end
		if (v_s1) begin
			point_s2 <= probe_s1;
			code_s2  <= word_s1.bucket_code;
			len_s2   <= eff_len;
			next_s2  <= eff_next;
		end
		if (s2_adv) begin
			out_word_q <= '{fused: match, group_id: group_s2, run_overflow: overflow_s2};
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// File: sv/pfwt_check.sv
// Port-level checker for the point fusion block, bound to its top level.
// Depends on pfwt_pkg for the word types.
module pfwt_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input pfwt_pkg::pfwt_in_t            in_word,
	input logic                          out_valid,
	input logic                          out_stall,
	input pfwt_pkg::pfwt_out_t           out_word,
	input logic                          cfg_we,
	input logic [pfwt_pkg::TOL_BITS-1:0] cfg_wdata
);

	logic tol_zero_q;
	logic in_acc;

	assign in_acc = in_valid && !in_stall;

	// track whether the tolerance is zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_zero_q <= 1'b1;
		end else if (cfg_we) begin
			tol_zero_q <= (cfg_wdata == '0);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled output word changed or dropped");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_acc)
		else $error("two words accepted on back-to-back edges");

	a_result_shows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> ##3 out_valid)
		else $error("no output word three edges after an accepted word");

	a_zero_tol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tol_zero_q |-> !out_word.fused)
		else $error("word fused with zero tolerance");

	logic unused_in;
	assign unused_in = ^in_word;

endmodule

bind point_fuse_within_tolerance pfwt_check u_pfwt_check (.*);
